// ----- rtl/core/acpu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// acpu_pkg
// opcodes and field widths of the accumulator cpu execute unit
// ----------------------------------------------------------------------------
package acpu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 5'd1,
        OP_ADDI = 5'd2,
        OP_ADDM = 5'd3,
        OP_AND  = 5'd4,
        OP_ANDI = 5'd5,
        OP_ANDM = 5'd6,
        OP_OR   = 5'd7,
        OP_ORI  = 5'd8,
        OP_ORM  = 5'd9,
        OP_SUB  = 5'd10,
        OP_SUBI = 5'd11,
        OP_SUBM = 5'd12,
        OP_INC  = 5'd13,
        OP_DEC  = 5'd14,
        OP_SHL  = 5'd15,
        OP_SHR  = 5'd16,
        OP_BRE  = 5'd17,
        OP_BRN  = 5'd18,
        OP_J    = 5'd19,
        OP_NOR  = 5'd20,
        OP_LDA  = 5'd21,
        OP_STR  = 5'd22,
        OP_SWP  = 5'd23,
        OP_LESS = 5'd24,
        OP_GRT  = 5'd25,
        OP_PRI  = 5'd26,
        OP_PRII = 5'd27,
        OP_PRIM = 5'd28,
        OP_EXIT = 5'd29
    } op_t;

    // result of one executed item
    typedef struct packed {
        logic              halted;
        logic              addr_error;
        logic [BYTE_W-1:0] print_value;
        logic              print_valid;
        logic [BYTE_W-1:0] next_line;
        logic [BYTE_W-1:0] acc_b;
        logic [BYTE_W-1:0] acc_a;
    } result_t;

    function automatic logic is_mem_op(input logic [OP_W-1:0] op);
        logic r;
        r = (op == OP_ADDM) || (op == OP_ANDM) || (op == OP_ORM) || (op == OP_SUBM) ||
            (op == OP_LDA)  || (op == OP_STR)  || (op == OP_PRIM);
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/accumulator_cpu_execute_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit
// executes one decoded instruction of a two-register 8-bit machine per item,
// with a synchronous data memory read one stage ahead of execute
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake                 payload
//  s_axis    in    s_tvalid / s_tready       s_tdata[15:0]  req_type, operand_value
//  m_axis    out   m_tvalid / m_tready       m_tdata[39:0]  result fields
//
//  one item per cycle sustained while the output is not stalled
//  stage 1 registers the item and reads the data memory at operand_value
//  stage 2 executes against a, b and the line counter and writes memory back;
//  a write in the cycle an item was read is forwarded to it
//  reset clears a, b, line counter, halt flag and the per-cell valid bits
//  (a cell not yet written reads as zero); no clearing pass is needed
//  a stalled output holds stage 2, stage 1 then holds its item and read data
//
module accumulator_cpu_execute_unit #(
    parameter int unsigned MEM_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // fields from bit 0: req_type[4:0], operand_value[12:5], zero [15:13]
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // fields from bit 0: acc_a[7:0], acc_b[15:8], next_line[23:16],
    // print_valid[24], print_value[32:25], addr_error[33], halted[34], zero [39:35]
    output logic [39:0]      m_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready
);

    localparam int unsigned AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [8:0] DEPTH_LIM = 9'(MEM_DEPTH);

    // data memory and per-cell valid bits
    logic [acpu_pkg::BYTE_W-1:0] mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0]        cell_valid_reg;

    // stage 1: accepted item and its memory read
    logic                        s1_valid_reg;
    logic [acpu_pkg::OP_W-1:0]   s1_op_reg;
    logic [acpu_pkg::BYTE_W-1:0] s1_v_reg;
    logic [acpu_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_cell_valid_reg;

    // last write, kept for forwarding into stage 1's read
    logic                        wr_valid_reg;
    logic [AW-1:0]               wr_addr_reg;
    logic [acpu_pkg::BYTE_W-1:0] wr_data_reg;

    // architectural state
    logic [acpu_pkg::BYTE_W-1:0] a_reg;
    logic [acpu_pkg::BYTE_W-1:0] b_reg;
    logic [acpu_pkg::BYTE_W-1:0] line_reg;
    logic                        halt_reg;

    // output register
    logic                        out_valid_reg;
    acpu_pkg::result_t           out_reg;

    logic                        in_accept;
    logic                        exec;
    logic [acpu_pkg::OP_W-1:0]   in_op;
    logic [acpu_pkg::BYTE_W-1:0] in_v;
    logic                        in_addr_ok;

    assign in_op      = s_tdata[4:0];
    assign in_v       = s_tdata[12:5];
    assign in_addr_ok = {1'b0, in_v} < DEPTH_LIM;

    assign exec      = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || exec;
    assign in_accept = s_tvalid && s_tready;

    // execute
    logic                        s1_addr_ok;
    logic [AW-1:0]               s1_addr;
    logic [acpu_pkg::BYTE_W-1:0] m_val;
    logic [acpu_pkg::BYTE_W-1:0] a_next;
    logic [acpu_pkg::BYTE_W-1:0] b_next;
    logic [acpu_pkg::BYTE_W-1:0] cur_line;
    logic [acpu_pkg::BYTE_W-1:0] next_line;
    logic                        halt_next;
    logic                        pv;
    logic [acpu_pkg::BYTE_W-1:0] pval;
    logic                        aerr;
    logic                        mem_we;

    assign s1_addr_ok = {1'b0, s1_v_reg} < DEPTH_LIM;
    assign s1_addr    = s1_v_reg[AW-1:0];
    assign cur_line   = line_reg + 8'd1;

    always_comb
    begin
        // forward the write that landed in the cycle this item was read
        if (wr_valid_reg && (wr_addr_reg == s1_addr))
            m_val = wr_data_reg;
        else if (rd_cell_valid_reg)
            m_val = rd_data_reg;
        else
            m_val = '0;

        a_next    = a_reg;
        b_next    = b_reg;
        next_line = cur_line + 8'd1;
        halt_next = halt_reg;
        pv        = 1'b0;
        pval      = '0;
        aerr      = 1'b0;
        mem_we    = 1'b0;

        if (halt_reg)
        begin
            // frozen: report the line after the last one executed
            next_line = cur_line;
        end
        else
        begin
            if (acpu_pkg::is_mem_op(s1_op_reg) && !s1_addr_ok)
                aerr = 1'b1;
            unique case (s1_op_reg)
                acpu_pkg::OP_ADD:  a_next = a_reg + b_reg;
                acpu_pkg::OP_ADDI: a_next = a_reg + s1_v_reg;
                acpu_pkg::OP_AND:  a_next = a_reg & b_reg;
                acpu_pkg::OP_ANDI: a_next = a_reg & s1_v_reg;
                acpu_pkg::OP_OR:   a_next = a_reg | b_reg;
                acpu_pkg::OP_ORI:  a_next = a_reg | s1_v_reg;
                acpu_pkg::OP_SUB:  a_next = a_reg - b_reg;
                acpu_pkg::OP_SUBI: a_next = a_reg - s1_v_reg;
                acpu_pkg::OP_ADDM:
                    if (s1_addr_ok)
                    begin
                        a_next = a_reg + m_val;
                        mem_we = 1'b1;
                    end
                acpu_pkg::OP_ANDM:
                    if (s1_addr_ok)
                    begin
                        a_next = a_reg & m_val;
                        mem_we = 1'b1;
                    end
                acpu_pkg::OP_ORM:
                    if (s1_addr_ok)
                    begin
                        a_next = a_reg | m_val;
                        mem_we = 1'b1;
                    end
                acpu_pkg::OP_SUBM:
                    if (s1_addr_ok)
                    begin
                        a_next = a_reg - m_val;
                        mem_we = 1'b1;
                    end
                acpu_pkg::OP_INC:  a_next = a_reg + 8'd1;
                acpu_pkg::OP_DEC:  b_next = b_reg - 8'd1;
                acpu_pkg::OP_SHL:
                    a_next = (s1_v_reg >= 8'd8) ? '0 : (a_reg << s1_v_reg[2:0]);
                acpu_pkg::OP_SHR:
                    a_next = (s1_v_reg >= 8'd8) ? '0 : (a_reg >> s1_v_reg[2:0]);
                acpu_pkg::OP_BRE:
                    if (a_reg == b_reg)
                        next_line = s1_v_reg;
                acpu_pkg::OP_BRN:
                    if (a_reg != b_reg)
                        next_line = s1_v_reg;
                acpu_pkg::OP_J:    next_line = s1_v_reg;
                acpu_pkg::OP_NOR:  a_next = ~(a_reg | b_reg);
                acpu_pkg::OP_LDA:
                    if (s1_addr_ok)
                        a_next = m_val;
                acpu_pkg::OP_STR:
                    if (s1_addr_ok)
                        mem_we = 1'b1;
                acpu_pkg::OP_SWP:
                begin
                    a_next = b_reg;
                    b_next = a_reg;
                end
                acpu_pkg::OP_LESS: a_next = (a_reg < b_reg) ? 8'd1 : 8'd0;
                acpu_pkg::OP_GRT:  a_next = (a_reg > b_reg) ? 8'd1 : 8'd0;
                acpu_pkg::OP_PRI:
                begin
                    pv   = 1'b1;
                    pval = a_reg;
                end
                acpu_pkg::OP_PRII:
                begin
                    pv   = 1'b1;
                    pval = s1_v_reg;
                end
                acpu_pkg::OP_PRIM:
                    if (s1_addr_ok)
                    begin
                        pv   = 1'b1;
                        pval = m_val;
                    end
                acpu_pkg::OP_EXIT: halt_next = 1'b1;
                default: ;
            endcase
        end
    end

    // memory array: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (exec && mem_we)
            mem[s1_addr] <= a_next;
        if (in_accept && in_addr_ok)
            rd_data_reg <= mem[in_v[AW-1:0]];
    end

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_valid_reg    <= '0;
            rd_cell_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec && mem_we)
                cell_valid_reg[s1_addr] <= 1'b1;
            if (in_accept)
                rd_cell_valid_reg <= in_addr_ok && cell_valid_reg[in_v[AW-1:0]];
        end
    end

    // stage 1 payload, last write for forwarding, output payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg <= in_op;
            s1_v_reg  <= in_v;
        end
        if (exec)
        begin
            wr_addr_reg <= s1_addr;
            wr_data_reg <= a_next;
            out_reg     <= '{halted:      halt_next,
                             addr_error:  aerr,
                             print_value: pval,
                             print_valid: pv,
                             next_line:   next_line,
                             acc_b:       b_next,
                             acc_a:       a_next};
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wr_valid_reg  <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            line_reg      <= '0;
            halt_reg      <= 1'b0;
        end
        else
        begin
            if (in_accept)
                s1_valid_reg <= 1'b1;
            else if (exec)
                s1_valid_reg <= 1'b0;

            if (exec)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (exec)
            begin
                wr_valid_reg <= mem_we;
                a_reg        <= a_next;
                b_reg        <= b_next;
                line_reg     <= next_line - 8'd1;
                halt_reg     <= halt_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg};

    // halt is sticky
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(halt_reg) |-> halt_reg)
        else $error("halt flag cleared");

    // a stalled stage 1 keeps its item
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !exec) |=> (s1_valid_reg && $stable(s1_op_reg) && $stable(s1_v_reg)))
        else $error("stage 1 item lost while stalled");

    // a bad address never prints
    a_err_no_print: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.addr_error) |-> !out_reg.print_valid)
        else $error("print on bad address");

    // frozen machine reports no error or print, only halted
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && halt_reg) |=> (!out_reg.addr_error && !out_reg.print_valid
                                && out_reg.halted))
        else $error("flags after halt");

endmodule
`default_nettype wire

// ----- sim/accumulator_cpu_execute_unit_monitor.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit_monitor
// watches both stream channels of the execute unit, runs its own copy of the
// machine on every accepted instruction and checks each result in order
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit_monitor
    import acpu_pkg::*;
#(
    parameter int unsigned MEM_DEPTH = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] s_tdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    output int unsigned      mismatch_count,
    output int unsigned      outstanding
);

    // machine state as the unit should hold it
    logic [BYTE_W-1:0] reg_a;
    logic [BYTE_W-1:0] reg_b;
    logic [BYTE_W-1:0] data_mem [MEM_DEPTH];
    logic [BYTE_W-1:0] last_line;
    logic              halt_seen;

    result_t     pending_results [$];
    int unsigned result_index;

    task automatic execute_instruction(input logic [OP_W-1:0] op,
                                       input logic [BYTE_W-1:0] opnd,
                                       output result_t res);
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] m;
        logic [BYTE_W-1:0] cur;
        logic [BYTE_W-1:0] nxt;
        logic              addr_ok;
        logic              mem_form;
        a        = reg_a;
        b        = reg_b;
        m        = '0;
        cur      = last_line + 8'd1;
        nxt      = cur + 8'd1;
        addr_ok  = (opnd < MEM_DEPTH);
        mem_form = op inside {OP_ADDM, OP_ANDM, OP_ORM, OP_SUBM, OP_LDA, OP_STR, OP_PRIM};
        res      = '0;
        if (halt_seen) begin
            // frozen: report the line after the last one executed
            res.acc_a     = a;
            res.acc_b     = b;
            res.next_line = cur;
            res.halted    = 1'b1;
            return;
        end
        if (mem_form) begin
            if (addr_ok)
                m = data_mem[opnd];
            else
                res.addr_error = 1'b1;
        end
        case (op)
            OP_ADD:  a = a + b;
            OP_ADDI: a = a + opnd;
            OP_AND:  a = a & b;
            OP_ANDI: a = a & opnd;
            OP_OR:   a = a | b;
            OP_ORI:  a = a | opnd;
            OP_SUB:  a = a - b;
            OP_SUBI: a = a - opnd;
            OP_ADDM, OP_ANDM, OP_ORM, OP_SUBM:
            begin
                if (addr_ok) begin
                    case (op)
                        OP_ADDM: a = a + m;
                        OP_ANDM: a = a & m;
                        OP_ORM:  a = a | m;
                        default: a = a - m;
                    endcase
                    data_mem[opnd] = a;
                end
            end
            OP_INC:  a = a + 8'd1;
            OP_DEC:  b = b - 8'd1;
            OP_SHL:  a = (opnd >= 8) ? 8'd0 : (a << opnd);
            OP_SHR:  a = (opnd >= 8) ? 8'd0 : (a >> opnd);
            OP_BRE:  if (a == b) nxt = opnd;
            OP_BRN:  if (a != b) nxt = opnd;
            OP_J:    nxt = opnd;
            OP_NOR:  a = ~(a | b);
            OP_LDA:  if (addr_ok) a = m;
            OP_STR:  if (addr_ok) data_mem[opnd] = a;
            OP_SWP:
            begin
                b = reg_a;
                a = reg_b;
            end
            OP_LESS: a = (a < b) ? 8'd1 : 8'd0;
            OP_GRT:  a = (a > b) ? 8'd1 : 8'd0;
            OP_PRI:
            begin
                res.print_valid = 1'b1;
                res.print_value = a;
            end
            OP_PRII:
            begin
                res.print_valid = 1'b1;
                res.print_value = opnd;
            end
            OP_PRIM:
            begin
                if (addr_ok) begin
                    res.print_valid = 1'b1;
                    res.print_value = m;
                end
            end
            OP_EXIT: halt_seen = 1'b1;
            default: ;
        endcase
        reg_a         = a;
        reg_b         = b;
        last_line     = nxt - 8'd1;
        res.acc_a     = a;
        res.acc_b     = b;
        res.next_line = nxt;
        res.halted    = halt_seen;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("result %0d: %s expected 0x%0h, got 0x%0h",
                         result_index, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n) begin
            reg_a     = '0;
            reg_b     = '0;
            last_line = '0;
            halt_seen = 1'b0;
            foreach (data_mem[i])
                data_mem[i] = '0;
            pending_results.delete();
            result_index   = 0;
            mismatch_count = 0;
        end else begin
            // results first: none can belong to an item accepted at this edge
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[34:0]);
                if (pending_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("result %0d: unexpected, data 0x%0h", result_index, m_tdata);
                    mismatch_count++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("acc_a",       want.acc_a,       got.acc_a);
                    check_field("acc_b",       want.acc_b,       got.acc_b);
                    check_field("next_line",   want.next_line,   got.next_line);
                    check_field("print_valid", want.print_valid, got.print_valid);
                    check_field("print_value", want.print_value, got.print_value);
                    check_field("addr_error",  want.addr_error,  got.addr_error);
                    check_field("halted",      want.halted,      got.halted);
                end
                result_index++;
            end
            if (s_tvalid && s_tready) begin
                execute_instruction(s_tdata[4:0], s_tdata[12:5], want);
                pending_results.push_back(want);
            end
        end
        outstanding = pending_results.size();
    end

endmodule

// ----- sim/accumulator_cpu_execute_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accumulator_cpu_execute_unit_tb
// drives instruction items into the execute unit under random flow control;
// a monitor beside the unit predicts and checks every result
// ----------------------------------------------------------------------------
module accumulator_cpu_execute_unit_tb;
    import acpu_pkg::*;

    localparam int unsigned MEM_DEPTH      = 128;
    localparam int unsigned PHASE_ITEMS    = 550;
    localparam int unsigned DRAIN_LIMIT    = 5000;
    localparam longint      RUN_LIMIT_NS   = 64'd4_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic [15:0] s_tdata  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;

    int unsigned mismatch_count;
    int unsigned outstanding;

    // flow control knobs, percent of cycles
    int unsigned send_gap_pct = 0;
    int unsigned stall_pct    = 0;
    int unsigned items_sent   = 0;

    always #4 clk = ~clk;

    accumulator_cpu_execute_unit #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    accumulator_cpu_execute_unit_monitor #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    // result side back-pressure, redrawn every cycle
    always @(posedge clk)
        m_tready <= ($urandom_range(99, 0) >= stall_pct);

    // hard stop in case the unit locks up
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // one item on the slave channel; called and returns at a rising edge
    task automatic send_instruction(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] opnd);
        // idle cycles drawn one at a time so the idle share matches the knob
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, opnd, op};
        // ready is stable from the falling edge to the next rising edge
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        items_sent++;
    endtask

    // hold off the sender until every result has come back
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic send_random_instruction();
        logic [OP_W-1:0]   op;
        logic [BYTE_W-1:0] opnd;
        logic [BYTE_W-1:0] pick;
        int unsigned       sel;
        sel = $urandom_range(99, 0);
        if (sel < 5) begin
            // load a and b with one value, then branch on equality or inequality
            pick = 8'($urandom_range(255, 0));
            send_instruction(OP_ANDI, 8'h00);
            send_instruction(OP_ADDI, pick);
            send_instruction(OP_SWP, 8'($urandom_range(255, 0)));
            send_instruction(OP_ANDI, 8'h00);
            send_instruction(OP_ADDI, pick);
            send_instruction($urandom_range(1, 0) ? OP_BRE : OP_BRN,
                             8'($urandom_range(255, 0)));
            return;
        end
        // unknown opcodes now and then; exit only at the very end
        if (sel < 9)
            op = $urandom_range(1, 0) ? 5'd0 : 5'($urandom_range(31, 30));
        else
            op = 5'($urandom_range(OP_PRIM, OP_ADD));
        sel = $urandom_range(99, 0);
        if (op inside {OP_ADDM, OP_ANDM, OP_ORM, OP_SUBM, OP_LDA, OP_STR, OP_PRIM}) begin
            // a handful of hot cells keeps back-to-back hits on one address common
            if (sel < 70)
                opnd = 8'($urandom_range(7, 0));
            else if (sel < 85)
                opnd = 8'($urandom_range(MEM_DEPTH - 1, 0));
            else
                opnd = 8'($urandom_range(255, 0));
        end else if (op inside {OP_SHL, OP_SHR}) begin
            opnd = (sel < 80) ? 8'($urandom_range(9, 0)) : 8'($urandom_range(255, 0));
        end else begin
            opnd = 8'($urandom_range(255, 0));
        end
        send_instruction(op, opnd);
    endtask

    initial
    begin
        int unsigned guard;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phase 1: light sender gaps, heavy result stalls
        send_gap_pct = 8;
        stall_pct    = 79;

        // directed: wrap at both ends, memory forms at the edges of the
        // address range, every operation but exit, unknown opcodes
        send_instruction(OP_ADDI, 8'hFF);
        send_instruction(OP_SWP,  8'h00);
        send_instruction(OP_ADDI, 8'h80);
        send_instruction(OP_ADD,  8'h00);
        send_instruction(OP_SUB,  8'h00);
        send_instruction(OP_SUBI, 8'hFF);
        send_instruction(OP_STR,  8'h7F);
        send_instruction(OP_STR,  8'h80);
        send_instruction(OP_ADDM, 8'h7F);
        send_instruction(OP_ANDM, 8'hFF);
        send_instruction(OP_ORM,  8'h00);
        send_instruction(OP_SUBM, 8'h7F);
        send_instruction(OP_LDA,  8'h00);
        send_instruction(OP_PRIM, 8'h7F);
        send_instruction(OP_PRI,  8'h00);
        send_instruction(OP_PRII, 8'hFF);
        send_instruction(OP_INC,  8'h00);
        send_instruction(OP_SHL,  8'h07);
        send_instruction(OP_SHR,  8'h08);
        send_instruction(OP_DEC,  8'h00);
        send_instruction(OP_AND,  8'h00);
        send_instruction(OP_ORI,  8'hA5);
        send_instruction(OP_ANDI, 8'h3C);
        send_instruction(OP_OR,   8'h00);
        send_instruction(OP_NOR,  8'h00);
        send_instruction(OP_LESS, 8'h00);
        send_instruction(OP_GRT,  8'h00);
        send_instruction(OP_BRE,  8'h10);
        send_instruction(OP_BRN,  8'h20);
        send_instruction(OP_J,    8'hFF);
        send_instruction(5'd0,    8'h55);
        send_instruction(5'd31,   8'hAA);

        while (items_sent < PHASE_ITEMS)
            send_random_instruction();
        wait_results_drained();

        // phase 2: heavy sender gaps, light result stalls
        send_gap_pct = 79;
        stall_pct    = 8;
        while (items_sent < 2 * PHASE_ITEMS)
            send_random_instruction();
        wait_results_drained();

        // phase 3: full rate on both sides
        send_gap_pct = 0;
        stall_pct    = 0;
        while (items_sent < 3 * PHASE_ITEMS)
            send_random_instruction();

        // exit last: the machine stays frozen for everything after it
        send_instruction(OP_EXIT, 8'h00);
        send_instruction(OP_ADDI, 8'h01);
        send_instruction(OP_J,    8'h05);
        send_instruction(5'd30,   8'hFF);
        s_tvalid <= 1'b0;

        guard = 0;
        @(negedge clk);
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(negedge clk);
            guard++;
        end
        // keep watching to catch any stray result
        repeat (8) @(negedge clk);

        if (mismatch_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
